@@ hdl/sbsr_pkg.sv @@
// ----------------------------------------------------------------------------
// sbsr_pkg - shared types and constants
// Word layouts, command codes, response codes, configuration indexes and
// reset values for the single-bus sensor reader.
// ----------------------------------------------------------------------------
package sbsr_pkg;

    // Width of every configuration register and of the config data bus
    localparam int unsigned CFG_WIDTH     = 16;
    localparam int unsigned CFG_IDX_WIDTH = 3;
    localparam int unsigned BYTE_WIDTH    = 8;

    // Command codes carried by an input word
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Response codes
    localparam logic [1:0] RESP_ABSENT  = 2'd0;
    localparam logic [1:0] RESP_PRESENT = 2'd1;
    localparam logic [1:0] RESP_BAD     = 2'd2;
    localparam logic [1:0] RESP_TIMEOUT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_START_LOW     = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RELEASE       = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RESPONSE_WAIT = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RESPONSE_HIGH = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BIT_SAMPLE    = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TIMEOUT       = 3'd5;

    // Configuration reset values
    localparam logic [CFG_WIDTH-1:0] RST_START_LOW     = 16'd18000;
    localparam logic [CFG_WIDTH-1:0] RST_RELEASE       = 16'd20;
    localparam logic [CFG_WIDTH-1:0] RST_RESPONSE_WAIT = 16'd100;
    localparam logic [CFG_WIDTH-1:0] RST_RESPONSE_HIGH = 16'd80;
    localparam logic [CFG_WIDTH-1:0] RST_BIT_SAMPLE    = 16'd50;
    localparam logic [CFG_WIDTH-1:0] RST_TIMEOUT       = 16'd1000;

    typedef struct packed {
        logic [1:0] command;
        logic       line_level;
    } t_in_word;

    typedef struct packed {
        logic                  drive_low;
        logic                  busy_res;
        logic                  response_valid;
        logic [1:0]            response_code;
        logic                  byte_valid;
        logic [BYTE_WIDTH-1:0] data_byte;
        logic                  timed_out;
    } t_out_word;

endpackage

@@ hdl/single_bus_sensor_reader.sv @@
// ----------------------------------------------------------------------------
// single_bus_sensor_reader - single-wire humidity sensor protocol engine
// Results are registered: one shows in the cycle after its tick word is taken.
// Throughput: one tick word per cycle unless a result stalls; the state update
//   for a tick is one pass through the phase logic and saturating tick counter.
// The input side stays ready while a result waits if that result is taken
//   in the same cycle; the output register separates the two sides.
// Reset: synchronous, active low; phase idle, counters clear, config
//   registers return to their default timings.
// ----------------------------------------------------------------------------
module single_bus_sensor_reader
    import sbsr_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH   = 16,
    parameter int unsigned BITS_PER_READ = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data,
    // tick words in
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_word                 i_in_data,
    // result words out
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_word                o_out_data
);

    // Bit index counts up to BITS_PER_READ-1; one spare bit for the compare
    localparam int unsigned BIDX_WIDTH = 3;
    localparam logic [BIDX_WIDTH:0] LAST_BIT = (BIDX_WIDTH+1)'(BITS_PER_READ);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_LOW,
        PH_RELEASE,
        PH_RESP_WAIT,
        PH_RESP_HIGH,
        PH_RESP_FALL,
        PH_RD_RISE,
        PH_RD_DELAY,
        PH_RD_FALL
    } t_phase;

    // configuration
    logic [CFG_WIDTH-1:0] r_start_low, r_release, r_resp_wait;
    logic [CFG_WIDTH-1:0] r_resp_high, r_bit_sample, r_timeout;

    // protocol state
    t_phase                  r_phase, n_phase;
    logic [COUNT_WIDTH-1:0]  r_count, n_count;
    logic [BIDX_WIDTH-1:0]   r_bit_idx, n_bit_idx;
    logic [BYTE_WIDTH-1:0]   r_shift, n_shift;
    logic [1:0]              r_pend, n_pend;

    // result register
    logic                    r_out_valid;
    t_out_word               r_out, n_out;

    logic                    accept;
    logic [CFG_WIDTH-1:0]    limit;
    logic [COUNT_WIDTH-1:0]  cnt_next;
    logic                    cnt_reach;
    logic                    line;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign line        = i_in_data.line_level;

    // Which limit the counter compares against depends on the phase;
    // all edge waits share the timeout.
    always_comb begin
        unique case (r_phase)
            PH_START_LOW: limit = r_start_low;
            PH_RELEASE:   limit = r_release;
            PH_RESP_WAIT: limit = r_resp_wait;
            PH_RESP_HIGH: limit = r_resp_high;
            PH_RD_DELAY:  limit = r_bit_sample;
            default:      limit = r_timeout;
        endcase
    end

    sbsr_timer #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_timer (
        .i_count (r_count),
        .i_limit (limit),
        .o_next  (cnt_next),
        .o_reach (cnt_reach)
    );

    // Next state and result for the tick word at the input
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_bit_idx = r_bit_idx;
        n_shift   = r_shift;
        n_pend    = r_pend;
        n_out     = '0;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_in_data.command == CMD_START) begin
                    n_phase = PH_START_LOW;
                    n_count = '0;
                end else if (i_in_data.command == CMD_READ) begin
                    n_phase   = PH_RD_RISE;
                    n_count   = '0;
                    n_bit_idx = '0;
                    n_shift   = '0;
                end
            end
            PH_START_LOW: begin
                n_count = cnt_next;
                if (cnt_reach) begin
                    n_phase = PH_RELEASE;
                    n_count = '0;
                end
            end
            PH_RELEASE: begin
                n_count = cnt_next;
                if (cnt_reach) begin
                    n_phase = PH_RESP_WAIT;
                    n_count = '0;
                end
            end
            PH_RESP_WAIT: begin
                n_count = cnt_next;
                if (cnt_reach) begin
                    n_count = '0;
                    if (!line) begin
                        n_phase = PH_RESP_HIGH;
                    end else begin
                        // no low response: sensor absent
                        n_pend  = RESP_ABSENT;
                        n_phase = PH_RESP_FALL;
                    end
                end
            end
            PH_RESP_HIGH: begin
                n_count = cnt_next;
                if (cnt_reach) begin
                    n_count = '0;
                    n_pend  = line ? RESP_PRESENT : RESP_BAD;
                    n_phase = PH_RESP_FALL;
                end
            end
            PH_RESP_FALL: begin
                if (!line) begin
                    n_phase             = PH_IDLE;
                    n_out.response_valid = 1'b1;
                    n_out.response_code  = r_pend;
                end else begin
                    n_count = cnt_next;
                    if (cnt_reach) begin
                        n_phase              = PH_IDLE;
                        n_out.response_valid = 1'b1;
                        n_out.response_code  = RESP_TIMEOUT;
                        n_out.timed_out      = 1'b1;
                    end
                end
            end
            PH_RD_RISE: begin
                if (line) begin
                    n_phase = PH_RD_DELAY;
                    n_count = '0;
                end else begin
                    n_count = cnt_next;
                    if (cnt_reach) begin
                        n_phase          = PH_IDLE;
                        n_out.byte_valid = 1'b1;
                        n_out.timed_out  = 1'b1;
                    end
                end
            end
            PH_RD_DELAY: begin
                n_count = cnt_next;
                if (cnt_reach) begin
                    n_shift = {r_shift[BYTE_WIDTH-2:0], line};
                    n_phase = PH_RD_FALL;
                    n_count = '0;
                end
            end
            PH_RD_FALL: begin
                if (!line) begin
                    n_count = '0;
                    if ({1'b0, r_bit_idx} + 1'b1 >= LAST_BIT) begin
                        n_phase          = PH_IDLE;
                        n_out.byte_valid = 1'b1;
                        n_out.data_byte  = r_shift;
                    end else begin
                        n_bit_idx = r_bit_idx + 1'b1;
                        n_phase   = PH_RD_RISE;
                    end
                end else begin
                    n_count = cnt_next;
                    if (cnt_reach) begin
                        n_phase          = PH_IDLE;
                        n_out.byte_valid = 1'b1;
                        n_out.timed_out  = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_count = '0;
            end
        endcase

        n_out.drive_low = (n_phase == PH_START_LOW);
        n_out.busy_res  = (n_phase != PH_IDLE);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_low  <= RST_START_LOW;
            r_release    <= RST_RELEASE;
            r_resp_wait  <= RST_RESPONSE_WAIT;
            r_resp_high  <= RST_RESPONSE_HIGH;
            r_bit_sample <= RST_BIT_SAMPLE;
            r_timeout    <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_START_LOW:     r_start_low  <= i_cfg_data;
                REG_RELEASE:       r_release    <= i_cfg_data;
                REG_RESPONSE_WAIT: r_resp_wait  <= i_cfg_data;
                REG_RESPONSE_HIGH: r_resp_high  <= i_cfg_data;
                REG_BIT_SAMPLE:    r_bit_sample <= i_cfg_data;
                REG_TIMEOUT:       r_timeout    <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // Phase machine state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_bit_idx   <= '0;
            r_shift     <= '0;
            r_pend      <= RESP_ABSENT;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_count     <= n_count;
                r_bit_idx   <= n_bit_idx;
                r_shift     <= n_shift;
                r_pend      <= n_pend;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

@@ hdl/sbsr_timer.sv @@
// ----------------------------------------------------------------------------
// sbsr_timer - saturating tick counter step
// Advances the tick count by one, saturating at the counter maximum, and
// flags when the advanced count reaches the limit or the maximum.
// ----------------------------------------------------------------------------
module sbsr_timer
    import sbsr_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  logic [CFG_WIDTH-1:0]   i_limit,
    output logic [COUNT_WIDTH-1:0] o_next,
    output logic                   o_reach
);

    localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [CMP_WIDTH-1:0] next_ext;
    logic [CMP_WIDTH-1:0] limit_ext;

    assign o_next    = (i_count == CNT_MAX) ? i_count : i_count + 1'b1;
    assign next_ext  = CMP_WIDTH'(o_next);
    assign limit_ext = CMP_WIDTH'(i_limit);
    assign o_reach   = (next_ext >= limit_ext) || (o_next == CNT_MAX);

endmodule

@@ hdl/sbsr_checker.sv @@
// ----------------------------------------------------------------------------
// sbsr_checker - port-level checks for the sensor reader
// Watches the result channel for consistent status fields over time.
// ----------------------------------------------------------------------------
module sbsr_checker
    import sbsr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // a finishing word never reports both a response and a byte
    a_one_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.response_valid && o_out_data.byte_valid))
        else $error("response and byte finished together");

    // a timeout only shows on a finishing word, and a response timeout uses its code
    a_timeout_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.timed_out |->
            o_out_data.byte_valid ||
            (o_out_data.response_valid && o_out_data.response_code == RESP_TIMEOUT))
        else $error("timeout flagged without a finish");

    // finishing returns to idle; the start pulse only runs while busy
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.response_valid || o_out_data.byte_valid ||
                        o_out_data.drive_low) |->
            (o_out_data.busy_res == o_out_data.drive_low))
        else $error("busy flag inconsistent with finish or start pulse");

endmodule

bind single_bus_sensor_reader sbsr_checker u_sbsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
